### hdl/lts_pkg.sv
package lts_pkg;

  localparam int KIND_W   = 2;
  localparam int ENTRY_W  = 4;
  localparam int ID_W     = 16;
  localparam int FIELD_TW = 8;
  localparam int BURST_W  = 16;
  localparam int STATUS_W = 3;
  localparam int WAIT_W   = 24;
  localparam int SLICE_W  = 16;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_DRAW = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  localparam logic [STATUS_W-1:0] STATUS_LOADED   = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_OWNER = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_RAN      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FINISHED = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_READBACK = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_SLICE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 1'd1;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ENTRY_W-1:0]  entry_index;
    logic [ID_W-1:0]     process_id;
    logic [FIELD_TW-1:0] range_end;
    logic [BURST_W-1:0]  burst;
    logic [FIELD_TW-1:0] drawn_ticket;
  } lts_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  winner_index;
    logic [ID_W-1:0]     winner_id;
    logic [BURST_W-1:0]  remaining;
    logic [WAIT_W-1:0]   waited;
  } lts_out_t;

endpackage

### hdl/lottery_ticket_scheduler.sv
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-----------------------------------
// request   | start_i, busy_o           | req_i (lts_in_t)
// response  | done_o (one-cycle strobe) | rsp_o (lts_out_t)
// config    | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// A load transaction writes the table when accepted and its response shows in the next cycle.
// A read transaction first registers the table read, then the read state registers the response.
// A draw walks over up to process_count entries (at most MAX_PROCS) of the table memory,
// one entry per cycle through its single read port; a count of zero answers no-owner at once.
// Reset clears the state machine, pointer, flags, process count and per-entry valid bits and sets the slice to 1.
// The receiver cannot stall: each response stands for exactly one cycle.
module lottery_ticket_scheduler
  import lts_pkg::*;
#(
  parameter int MAX_PROCS   = 16,
  parameter int TICKET_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  lts_in_t               req_i,
  output logic                  done_o,
  output lts_out_t              rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW       = $clog2(MAX_PROCS + 1);
  localparam int IDX_VALS = 2 ** ENTRY_W;
  localparam int WSUM_W   = WAIT_W + 1;

  // One table word holds everything the scheduler keeps about a process.
  typedef struct packed {
    logic [ID_W-1:0]        id;
    logic [TICKET_BITS-1:0] range_end;
    logic [BURST_W-1:0]     burst;
    logic [WAIT_W-1:0]      waited;
  } entry_t;

  // One-hot controller: idle, readback of one entry, walk over the table.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_WALK = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [SLICE_W-1:0]     slice_q;
  logic [COUNT_W-1:0]     count_q;
  logic [IW-1:0]          ptr_q, ptr_d;
  logic [TICKET_BITS-1:0] start_q, start_d;
  logic [TICKET_BITS-1:0] ticket_q, ticket_d;
  logic                   found_q, found_d;
  lts_out_t               win_q, win_d;
  logic                   done_q, done_d;
  lts_out_t               rsp_q, rsp_d;

  entry_t                 mem [MAX_PROCS];
  entry_t                 rd_q;
  logic                   rd_valid_q;
  logic                   valid_q [MAX_PROCS];

  logic                   mem_we;
  logic [IW-1:0]          mem_wa;
  entry_t                 mem_wd;
  logic [IW-1:0]          rd_addr;

  logic [IW-1:0]          idx_mod [IDX_VALS];
  logic [IW-1:0]          req_idx;
  logic [CW-1:0]          count_lim;
  logic                   accept;
  logic                   last;
  logic                   owns;
  logic [WAIT_W-1:0]      cur_wait;
  logic [WSUM_W-1:0]      wait_sum;
  entry_t                 upd;
  logic [STATUS_W-1:0]    cur_status;
  lts_out_t               cand;
  lts_out_t               no_owner;

  // The entry index wraps modulo the table depth; the residues are constants.
  for (genvar g = 0; g < IDX_VALS; g++) begin : g_mod
    localparam logic [IW-1:0] Res = IW'(g % MAX_PROCS);
    assign idx_mod[g] = Res;
  end
  assign req_idx = idx_mod[req_i.entry_index];

  // A count above the table depth is treated as the full table.
  assign count_lim = (32'(count_q) > 32'(MAX_PROCS)) ? CW'(MAX_PROCS) : CW'(count_q);

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Waiting time reads as zero for an entry that has never been written.
  assign cur_wait = rd_valid_q ? rd_q.waited : '0;
  assign wait_sum = {1'b0, cur_wait} + WSUM_W'(slice_q);

  // Ownership of the drawn ticket against the range that the walk has reached.
  assign owns = (ticket_q >= start_q) && (ticket_q < rd_q.range_end);
  assign last = (CW'(ptr_q) + CW'(1)) == count_lim;

  always_comb begin
    upd        = rd_q;
    upd.waited = cur_wait;
    if (rd_q.burst != '0) begin
      if (owns) begin
        upd.burst = (rd_q.burst > slice_q) ? (rd_q.burst - slice_q) : '0;
      end else begin
        upd.waited = wait_sum[WAIT_W] ? WAIT_MAX : wait_sum[WAIT_W-1:0];
      end
    end
    if (rd_q.burst == '0) begin
      cur_status = STATUS_DONE;
    end else if (upd.burst == '0) begin
      cur_status = STATUS_FINISHED;
    end else begin
      cur_status = STATUS_RAN;
    end
  end

  always_comb begin
    cand.status       = cur_status;
    cand.winner_index = ENTRY_W'(ptr_q);
    cand.winner_id    = upd.id;
    cand.remaining    = upd.burst;
    cand.waited       = upd.waited;
    no_owner          = '0;
    no_owner.status   = STATUS_NO_OWNER;
  end

  // Memory port control. During the walk the entry that just arrived is
  // written back while the next one is read, so the two never collide.
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = ptr_q;
    mem_wd  = upd;
    rd_addr = ptr_q + IW'(1);
    if (accept) begin
      mem_wa           = req_idx;
      mem_wd.id        = req_i.process_id;
      mem_wd.range_end = TICKET_BITS'(req_i.range_end);
      mem_wd.burst     = req_i.burst;
      mem_wd.waited    = '0;
      mem_we           = (req_i.kind == KIND_LOAD);
      rd_addr          = (req_i.kind == KIND_DRAW) ? '0 : req_idx;
    end else if (state_q == ST_WALK) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        valid_q[i] <= 1'b0;
      end
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[mem_wa] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr];
    end
  end

  // Transaction sequencing and the response register.
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    start_d  = start_q;
    ticket_d = ticket_q;
    found_d  = found_q;
    win_d    = win_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.kind)
            KIND_LOAD: begin
              done_d             = 1'b1;
              rsp_d.status       = STATUS_LOADED;
              rsp_d.winner_index = ENTRY_W'(req_idx);
              rsp_d.winner_id    = req_i.process_id;
              rsp_d.remaining    = req_i.burst;
              rsp_d.waited       = '0;
            end
            KIND_DRAW: begin
              ticket_d = TICKET_BITS'(req_i.drawn_ticket);
              start_d  = '0;
              ptr_d    = '0;
              found_d  = 1'b0;
              if (count_lim == '0) begin
                done_d = 1'b1;
                rsp_d  = no_owner;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: begin
              ptr_d   = req_idx;
              state_d = ST_READ;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d             = 1'b1;
        rsp_d.status       = STATUS_READBACK;
        rsp_d.winner_index = ENTRY_W'(ptr_q);
        rsp_d.winner_id    = rd_q.id;
        rsp_d.remaining    = rd_q.burst;
        rsp_d.waited       = cur_wait;
        state_d            = ST_IDLE;
      end
      ST_WALK: begin
        // The next range starts where this entry's range ends.
        start_d = rd_q.range_end;
        ptr_d   = ptr_q + IW'(1);
        if (owns && !found_q) begin
          found_d = 1'b1;
          win_d   = cand;
        end
        if (last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          if (found_q) begin
            rsp_d = win_q;
          end else if (owns) begin
            rsp_d = cand;
          end else begin
            rsp_d = no_owner;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      slice_q <= SLICE_W'(1);
      count_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIME_SLICE:    slice_q <= cfg_data_i[SLICE_W-1:0];
          REG_PROCESS_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q  <= start_d;
    ticket_q <= ticket_d;
    win_q    <= win_d;
    rsp_q    <= rsp_d;
  end

endmodule

### hdl/lts_checker.sv
module lts_props
  import lts_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_i,
  input lts_in_t  req_i,
  input logic     done_i,
  input lts_out_t rsp_i
);

  // A load is answered in the very next cycle without going busy.
  a_load_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (req_i.kind == KIND_LOAD) |=> done_i && !busy_i)
    else $error("load transaction not answered in the next cycle");

  // A read, and the unnamed kind that behaves as one, always passes through a busy cycle.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (req_i.kind != KIND_LOAD) && (req_i.kind != KIND_DRAW) |=> busy_i)
    else $error("read transaction did not go busy");

  // Leaving the busy state always delivers the response.
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> done_i)
    else $error("busy ended without a response");

  // A draw without an owner reports an all-zero entry.
  a_no_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && (rsp_i.status == STATUS_NO_OWNER) |->
      (rsp_i.winner_index == '0) && (rsp_i.winner_id == '0) &&
      (rsp_i.remaining == '0) && (rsp_i.waited == '0))
    else $error("no-owner response carries nonzero fields");

  // A freshly loaded entry has waited for nothing.
  a_load_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && (rsp_i.status == STATUS_LOADED) |-> (rsp_i.waited == '0))
    else $error("load response reports a waiting time");

endmodule

bind lottery_ticket_scheduler lts_props u_lts_props (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .req_i   (req_i),
  .done_i  (done_o),
  .rsp_i   (rsp_o)
);
